// ===== sv/assert_macros.svh =====
// Assertion macros for the raycaster RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock edge, off while reset is high.
`define DGR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication form of the above.
`define DGR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== sv/dgr_pkg.sv =====
// Shared constants for the grid raycaster.
package dgr_pkg;

   localparam int FRAC_BITS     = 16;
   localparam int MAP_SIZE_DEF  = 64;
   localparam int MAX_STEPS_DEF = 128;

   // Serial divider operand width (numerator and divisor).
   localparam int DIV_W = 34;

   localparam logic [31:0] DIST_MAX = 32'hFFFF_FFFF;

   localparam logic        OP_CELL_WRITE = 1'b0;
   localparam logic        OP_CAST       = 1'b1;

   localparam logic [2:0]  REG_POS_X        = 3'd0;
   localparam logic [2:0]  REG_POS_Y        = 3'd1;
   localparam logic [2:0]  REG_VIEW_DIR_X   = 3'd2;
   localparam logic [2:0]  REG_VIEW_DIR_Y   = 3'd3;
   localparam logic [2:0]  REG_CAM_PLANE_X  = 3'd4;
   localparam logic [2:0]  REG_CAM_PLANE_Y  = 3'd5;
   localparam logic [2:0]  REG_SCREEN_WIDTH = 3'd6;

   localparam logic [21:0]        POS_X_RST        = 22'd2129920;
   localparam logic [21:0]        POS_Y_RST        = 22'd2129920;
   localparam logic signed [17:0] VIEW_DIR_X_RST   = -18'sd65536;
   localparam logic signed [17:0] VIEW_DIR_Y_RST   = 18'sd0;
   localparam logic signed [17:0] CAM_PLANE_X_RST  = 18'sd0;
   localparam logic signed [17:0] CAM_PLANE_Y_RST  = 18'sd43254;
   localparam logic [12:0]        SCREEN_WIDTH_RST = 13'd640;

endpackage

// ===== sv/dda_grid_raycaster_unit.sv =====
// Grid raycaster top level: configuration, cast sequencer and result register.
//
//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/req_tready | tdata cell/column fields, tuser opcode
//  rsp     | out | rsp_tvalid/rsp_tready | tdata column/hit/distance, tuser flags
//  csr     | in  | csr_valid/csr_ready   | csr_index, csr_wdata
//
// A cell write goes into the map as it is accepted. From acceptance to its first
// map step a cast runs three passes of the shared serial divider (a zero ray
// component skipping its pass) plus four multiplies and their adds, then each map
// step passes ST_STEP and ST_WAIT (the registered map read), for at most MAX_STEPS
// steps, and ST_FIN loads the result. After reset the map is swept to zero with
// req_tready low. A finished result waits in the output register while the next
// transaction is taken; a cast only stalls at its end if that is still full.
`include "assert_macros.svh"
module dda_grid_raycaster_unit #(
   parameter int MAP_SIZE  = dgr_pkg::MAP_SIZE_DEF,
   parameter int MAX_STEPS = dgr_pkg::MAX_STEPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [5:0] cell_row, [11:6] cell_col, [19:12] cell_value, [31:20] column
   input  logic [31:0] req_tdata,
   // [0] opcode
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [11:0] column_out, [17:12] hit_row, [23:18] hit_col, [31:24] wall_value,
   // [63:32] wall_distance
   output logic [63:0] rsp_tdata,
   // [0] hit_found, [1] hit_side
   output logic [1:0]  rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [21:0] csr_wdata
);
   localparam int FB   = dgr_pkg::FRAC_BITS;
   localparam int AW   = $clog2(MAP_SIZE * MAP_SIZE);
   localparam int CW   = $clog2(MAP_SIZE) + 2;
   localparam int NSW  = $clog2(MAX_STEPS + 1);
   localparam int DW   = dgr_pkg::DIV_W;
   localparam logic signed [CW-1:0] MAP_LIM = CW'(MAP_SIZE);

   typedef enum logic [4:0] {
      ST_IDLE, ST_CAM, ST_MX, ST_RX, ST_MY, ST_RY, ST_DX, ST_DXW, ST_DY, ST_DYW,
      ST_SXM, ST_SX, ST_SYM, ST_SY, ST_STEP, ST_WAIT, ST_FIN
   } state_type;

   // ---------------- configuration
   logic [21:0]        pos_x_ff, pos_y_ff;
   logic signed [17:0] view_dir_x_ff, view_dir_y_ff, cam_plane_x_ff, cam_plane_y_ff;
   logic [12:0]        screen_width_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff        <= dgr_pkg::POS_X_RST;
         pos_y_ff        <= dgr_pkg::POS_Y_RST;
         view_dir_x_ff   <= dgr_pkg::VIEW_DIR_X_RST;
         view_dir_y_ff   <= dgr_pkg::VIEW_DIR_Y_RST;
         cam_plane_x_ff  <= dgr_pkg::CAM_PLANE_X_RST;
         cam_plane_y_ff  <= dgr_pkg::CAM_PLANE_Y_RST;
         screen_width_ff <= dgr_pkg::SCREEN_WIDTH_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            dgr_pkg::REG_POS_X:        pos_x_ff        <= csr_wdata;
            dgr_pkg::REG_POS_Y:        pos_y_ff        <= csr_wdata;
            dgr_pkg::REG_VIEW_DIR_X:   view_dir_x_ff   <= csr_wdata[17:0];
            dgr_pkg::REG_VIEW_DIR_Y:   view_dir_y_ff   <= csr_wdata[17:0];
            dgr_pkg::REG_CAM_PLANE_X:  cam_plane_x_ff  <= csr_wdata[17:0];
            dgr_pkg::REG_CAM_PLANE_Y:  cam_plane_y_ff  <= csr_wdata[17:0];
            dgr_pkg::REG_SCREEN_WIDTH: screen_width_ff <= csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   // ---------------- request fields
   logic [5:0]  in_row, in_col;
   logic [7:0]  in_value;
   logic [11:0] in_column;
   logic        req_acc;

   assign in_row    = req_tdata[5:0];
   assign in_col    = req_tdata[11:6];
   assign in_value  = req_tdata[19:12];
   assign in_column = req_tdata[31:20];

   state_type state_ff;
   logic      map_clearing;

   assign req_tready = (state_ff == ST_IDLE) && !map_clearing;
   assign req_acc    = req_tvalid && req_tready;

   // ---------------- map
   logic          map_wr_en;
   logic [AW-1:0] map_wr_addr, map_rd_addr;
   logic [7:0]    map_rd_data;

   assign map_wr_en = req_acc && (req_tuser == dgr_pkg::OP_CELL_WRITE)
                      && (32'(in_row) < MAP_SIZE) && (32'(in_col) < MAP_SIZE);
   assign map_wr_addr = AW'(32'(in_row) * MAP_SIZE + 32'(in_col));

   dgr_map #(.MAP_SIZE(MAP_SIZE)) u_map (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (map_wr_en),
      .wr_addr  (map_wr_addr),
      .wr_data  (in_value),
      .rd_addr  (map_rd_addr),
      .rd_data  (map_rd_data),
      .clearing (map_clearing)
   );

   // ---------------- working registers
   logic [11:0]        column_ff;
   logic signed [30:0] cam_ff;
   logic signed [51:0] prod_ff;
   logic signed [33:0] rdx_ff, rdy_ff;
   logic [31:0]        dx_ff, dy_ff, sx_ff, sy_ff, dist_ff;
   logic signed [CW-1:0] mx_ff, my_ff;
   logic [NSW-1:0]     n_ff;
   logic               side_ff, hit_ff;
   logic [7:0]         wall_ff;

   // ---------------- shared divider
   logic          div_start, div_busy, div_done;
   logic [DW-1:0] div_num, div_den, div_q;
   logic [33:0]   abs_rdx, abs_rdy;
   logic [12:0]   width_eff;

   assign width_eff = (screen_width_ff == 13'd0) ? 13'd1 : screen_width_ff;
   assign abs_rdx   = rdx_ff[33] ? 34'(-rdx_ff) : 34'(rdx_ff);
   assign abs_rdy   = rdy_ff[33] ? 34'(-rdy_ff) : 34'(rdy_ff);

   always_comb begin
      div_start = 1'b0;
      div_num   = DW'(64'd1 << (2 * FB));
      div_den   = DW'(abs_rdx);
      priority if (req_acc && req_tuser == dgr_pkg::OP_CAST) begin
         div_start = 1'b1;
         div_num   = DW'({in_column, 1'b0}) << FB;
         div_den   = DW'(width_eff);
      end else if (state_ff == ST_DX) begin
         div_start = (rdx_ff != '0);
      end else if (state_ff == ST_DY) begin
         div_start = (rdy_ff != '0);
         div_den   = DW'(abs_rdy);
      end else begin
         div_start = 1'b0;
      end
   end

   dgr_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_q)
   );

   logic [31:0] div_sat;
   assign div_sat = (div_q[DW-1:32] != '0) ? dgr_pkg::DIST_MAX : div_q[31:0];

   // ---------------- shared multiplier operands
   logic signed [18:0] mul_a;
   logic signed [32:0] mul_b;
   logic [16:0]        span_x, span_y;

   assign span_x = rdx_ff[33] ? {1'b0, pos_x_ff[FB-1:0]} : 17'(1 << FB) - {1'b0, pos_x_ff[FB-1:0]};
   assign span_y = rdy_ff[33] ? {1'b0, pos_y_ff[FB-1:0]} : 17'(1 << FB) - {1'b0, pos_y_ff[FB-1:0]};

   always_comb begin
      unique case (state_ff)
         ST_MX:   begin mul_a = 19'(cam_plane_x_ff); mul_b = 33'(cam_ff); end
         ST_MY:   begin mul_a = 19'(cam_plane_y_ff); mul_b = 33'(cam_ff); end
         ST_SXM:  begin mul_a = {2'b00, span_x};     mul_b = {1'b0, dx_ff}; end
         ST_SYM:  begin mul_a = {2'b00, span_y};     mul_b = {1'b0, dy_ff}; end
         default: begin mul_a = '0;                  mul_b = '0; end
      endcase
   end

   // floor(product / 2^FB) is the arithmetic shift
   logic signed [33:0] plane_term;
   logic [31:0]        first_sat;
   assign plane_term = {prod_ff[48], prod_ff[48:16]};
   assign first_sat  = prod_ff[48] ? dgr_pkg::DIST_MAX : prod_ff[47:16];

   // ---------------- one DDA step
   logic               x_step;
   logic [32:0]        sx_sum, sy_sum;
   logic signed [CW-1:0] nmx, nmy;
   logic               oob;

   assign x_step = sx_ff < sy_ff;
   assign sx_sum = {1'b0, sx_ff} + {1'b0, dx_ff};
   assign sy_sum = {1'b0, sy_ff} + {1'b0, dy_ff};
   assign nmx = x_step ? (rdx_ff[33] ? mx_ff - CW'(1) : mx_ff + CW'(1)) : mx_ff;
   assign nmy = x_step ? my_ff : (rdy_ff[33] ? my_ff - CW'(1) : my_ff + CW'(1));
   assign oob = nmx[CW-1] || nmy[CW-1] || (nmx >= MAP_LIM) || (nmy >= MAP_LIM);
   assign map_rd_addr = AW'(32'(unsigned'(nmx)) * MAP_SIZE + 32'(unsigned'(nmy)));

   logic [5:0] start_x, start_y;
   assign start_x = pos_x_ff[21:FB];
   assign start_y = pos_y_ff[21:FB];

   // ---------------- result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_data_ff;
   logic [1:0]  rsp_user_ff;
   logic        out_free;

   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = (state_ff == ST_FIN && out_free) ? 1'b1
                         : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_acc && req_tuser == dgr_pkg::OP_CAST) begin
                  column_ff <= in_column;
                  state_ff  <= ST_CAM;
               end
            end
            ST_CAM: begin
               if (div_done) begin
                  cam_ff   <= $signed({1'b0, div_q[29:0]}) - 31'sd65536;
                  state_ff <= ST_MX;
               end
            end
            ST_MX: begin
               prod_ff  <= 52'(mul_a * mul_b);
               state_ff <= ST_RX;
            end
            ST_RX: begin
               rdx_ff   <= plane_term + 34'(view_dir_x_ff);
               state_ff <= ST_MY;
            end
            ST_MY: begin
               prod_ff  <= 52'(mul_a * mul_b);
               state_ff <= ST_RY;
            end
            ST_RY: begin
               rdy_ff   <= plane_term + 34'(view_dir_y_ff);
               state_ff <= ST_DX;
            end
            ST_DX: begin
               // zero component: the ray never crosses that side
               dx_ff    <= dgr_pkg::DIST_MAX;
               state_ff <= (rdx_ff != '0) ? ST_DXW : ST_DY;
            end
            ST_DXW: begin
               if (div_done) begin
                  dx_ff    <= div_sat;
                  state_ff <= ST_DY;
               end
            end
            ST_DY: begin
               dy_ff    <= dgr_pkg::DIST_MAX;
               state_ff <= (rdy_ff != '0) ? ST_DYW : ST_SXM;
            end
            ST_DYW: begin
               if (div_done) begin
                  dy_ff    <= div_sat;
                  state_ff <= ST_SXM;
               end
            end
            ST_SXM: begin
               prod_ff  <= 52'(mul_a * mul_b);
               state_ff <= ST_SX;
            end
            ST_SX: begin
               sx_ff    <= first_sat;
               state_ff <= ST_SYM;
            end
            ST_SYM: begin
               prod_ff  <= 52'(mul_a * mul_b);
               state_ff <= ST_SY;
            end
            ST_SY: begin
               sy_ff   <= first_sat;
               hit_ff  <= 1'b0;
               n_ff    <= '0;
               mx_ff   <= CW'(start_x);
               my_ff   <= CW'(start_y);
               if ((32'(start_x) < MAP_SIZE) && (32'(start_y) < MAP_SIZE)) begin
                  state_ff <= ST_STEP;
               end else begin
                  state_ff <= ST_FIN;
               end
            end
            ST_STEP: begin
               if (x_step) begin
                  dist_ff <= sx_ff;
                  sx_ff   <= sx_sum[32] ? dgr_pkg::DIST_MAX : sx_sum[31:0];
               end else begin
                  dist_ff <= sy_ff;
                  sy_ff   <= sy_sum[32] ? dgr_pkg::DIST_MAX : sy_sum[31:0];
               end
               side_ff  <= !x_step;
               mx_ff    <= nmx;
               my_ff    <= nmy;
               n_ff     <= n_ff + NSW'(1);
               state_ff <= oob ? ST_FIN : ST_WAIT;
            end
            ST_WAIT: begin
               wall_ff <= map_rd_data;
               if (map_rd_data != 8'd0) begin
                  hit_ff   <= 1'b1;
                  state_ff <= ST_FIN;
               end else if (n_ff == NSW'(MAX_STEPS)) begin
                  state_ff <= ST_FIN;
               end else begin
                  state_ff <= ST_STEP;
               end
            end
            ST_FIN: begin
               if (out_free) begin
                  if (hit_ff) begin
                     rsp_data_ff <= {dist_ff, wall_ff, 6'(unsigned'(my_ff)),
                                     6'(unsigned'(mx_ff)), column_ff};
                     rsp_user_ff <= {side_ff, 1'b1};
                  end else begin
                     rsp_data_ff <= {dgr_pkg::DIST_MAX, 20'd0, column_ff};
                     rsp_user_ff <= 2'b00;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // ---------------- checks
   `DGR_ASSERT_IMP(a_no_accept_while_clearing, clock, reset, map_clearing, !req_tready, "request taken during map clear")
   `DGR_ASSERT_IMP(a_div_start_idle, clock, reset, div_start, !div_busy, "divider restarted while busy")
   `DGR_ASSERT_IMP(a_miss_saturates, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tdata[63:32] == dgr_pkg::DIST_MAX, "miss without saturated distance")
   `DGR_ASSERT_IMP(a_walk_in_map, clock, reset, state_ff == ST_WAIT, !mx_ff[CW-1] && !my_ff[CW-1] && mx_ff < MAP_LIM && my_ff < MAP_LIM, "map read outside the grid")
endmodule

// ===== sv/dgr_div.sv =====
// Restoring divider, one quotient bit per cycle.
module dgr_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [dgr_pkg::DIV_W-1:0] num,
   input  logic [dgr_pkg::DIV_W-1:0] den,
   output logic                      busy,
   output logic                      done,
   output logic [dgr_pkg::DIV_W-1:0] quot
);
   localparam int W  = dgr_pkg::DIV_W;
   localparam int CNTW = $clog2(W);

   logic [W-1:0]    num_ff, den_ff, rem_ff, rem_in;
   logic [W:0]      rem_sh, diff;
   logic            ge;
   logic [CNTW-1:0] cnt_ff;
   logic            busy_ff, done_ff;

   assign rem_sh = {rem_ff, num_ff[W-1]};
   assign diff   = rem_sh - {1'b0, den_ff};
   assign ge     = rem_sh >= {1'b0, den_ff};
   assign rem_in = ge ? diff[W-1:0] : rem_sh[W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         // pulses on the cycle after the last quotient bit
         done_ff <= busy_ff && !start && (cnt_ff == CNTW'(W - 1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            num_ff  <= num;
            den_ff  <= den;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            // quotient bits shift in behind the numerator
            num_ff <= {num_ff[W-2:0], ge};
            cnt_ff <= cnt_ff + CNTW'(1);
            if (cnt_ff == CNTW'(W - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = num_ff;
endmodule

// ===== sv/dgr_map.sv =====
// Grid map memory with a clearing sweep after reset.
module dgr_map #(
   parameter int MAP_SIZE = dgr_pkg::MAP_SIZE_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  wr_en,
   input  logic [$clog2(MAP_SIZE*MAP_SIZE)-1:0]  wr_addr,
   input  logic [7:0]                            wr_data,
   input  logic [$clog2(MAP_SIZE*MAP_SIZE)-1:0]  rd_addr,
   output logic [7:0]                            rd_data,
   output logic                                  clearing
);
   localparam int DEPTH = MAP_SIZE * MAP_SIZE;
   localparam int AW    = $clog2(DEPTH);

   logic [7:0]    mem [DEPTH];
   logic [AW-1:0] clr_ff;
   logic          clearing_ff;
   logic [7:0]    rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_ff      <= '0;
      end else if (clearing_ff) begin
         clr_ff <= clr_ff + AW'(1);
         if (clr_ff == AW'(DEPTH - 1)) clearing_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_ff] <= 8'd0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   assign rd_data  = rd_ff;
   assign clearing = clearing_ff;
endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the grid raycaster: map writes, column casts and CSR settings.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAP_N      = dgr_pkg::MAP_SIZE_DEF;
   localparam int STEP_LIMIT = dgr_pkg::MAX_STEPS_DEF;
   localparam int WDOG_LIMIT = 20000;
   localparam int HOLD_LEN   = 400;
   localparam int DRAIN_WAIT = 400;

   typedef struct packed {
      logic [11:0] column_out;
      logic        hit_found;
      logic        hit_side;
      logic [5:0]  hit_row;
      logic [5:0]  hit_col;
      logic [7:0]  wall_value;
      logic [31:0] wall_distance;
   } ray_hit_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [21:0] csr_wdata;

   dda_grid_raycaster_unit dut (.*);

   always #5 clock = ~clock;

   // viewer state as the block should hold it
   logic [21:0]        view_pos_x, view_pos_y;
   logic signed [17:0] dir_x, dir_y, plane_x, plane_y;
   logic [12:0]        scr_width;
   logic [7:0]         wall_map [0:MAP_N*MAP_N-1];

   ray_hit_type pending_hits[$];
   int errors      = 0;
   int n_writes    = 0;
   int n_casts     = 0;
   int n_hits      = 0;
   int n_misses    = 0;
   int n_csr       = 0;
   int idle_cycles = 0;
   int req_idle_pct = 0;
   int rsp_stall_pct = 0;
   bit hold_req = 0;
   int hold_left = 0;

   function automatic longint unsigned clip_dist(longint unsigned v);
      return (v > 64'(dgr_pkg::DIST_MAX)) ? 64'(dgr_pkg::DIST_MAX) : v;
   endfunction

   function automatic longint unsigned cell_span(longint d);
      longint unsigned a;
      if (d == 0) return 64'(dgr_pkg::DIST_MAX);
      a = (d < 0) ? -d : d;
      return clip_dist((64'd1 << (2*dgr_pkg::FRAC_BITS)) / a);
   endfunction

   function automatic longint unsigned edge_dist(logic [21:0] p, longint d,
                                                 longint unsigned delta);
      longint unsigned frac, span;
      frac = p & ((1 << dgr_pkg::FRAC_BITS) - 1);
      span = (d < 0) ? frac : (64'd1 << dgr_pkg::FRAC_BITS) - frac;
      return clip_dist((span * delta) >> dgr_pkg::FRAC_BITS);
   endfunction

   function automatic ray_hit_type trace_column(logic [11:0] col);
      longint unsigned w, dx, dy, sx, sy, wall_dist;
      longint cam, rdx, rdy, mx, my;
      int sgx, sgy, side, n;
      bit hit;
      ray_hit_type r;
      w = (scr_width == 0) ? 1 : scr_width;
      cam = longint'(((64'(col) * 2) << dgr_pkg::FRAC_BITS) / w)
            - (longint'(1) << dgr_pkg::FRAC_BITS);
      rdx = longint'(dir_x) + ((longint'(plane_x) * cam) >>> dgr_pkg::FRAC_BITS);
      rdy = longint'(dir_y) + ((longint'(plane_y) * cam) >>> dgr_pkg::FRAC_BITS);
      dx = cell_span(rdx);
      dy = cell_span(rdy);
      sgx = (rdx < 0) ? -1 : 1;
      sgy = (rdy < 0) ? -1 : 1;
      sx = edge_dist(view_pos_x, rdx, dx);
      sy = edge_dist(view_pos_y, rdy, dy);
      mx = view_pos_x >> dgr_pkg::FRAC_BITS;
      my = view_pos_y >> dgr_pkg::FRAC_BITS;
      wall_dist = 64'(dgr_pkg::DIST_MAX);
      side = 0;
      hit = 0;
      if (mx < MAP_N && my < MAP_N) begin
         for (n = 0; n < STEP_LIMIT; n++) begin
            if (sx < sy) begin
               wall_dist = sx; sx = clip_dist(sx + dx); mx += sgx; side = 0;
            end else begin
               wall_dist = sy; sy = clip_dist(sy + dy); my += sgy; side = 1;
            end
            if (mx < 0 || my < 0 || mx >= MAP_N || my >= MAP_N) break;
            if (wall_map[mx*MAP_N + my] != 0) begin
               hit = 1;
               break;
            end
         end
      end
      r = '0;
      r.column_out = col;
      r.wall_distance = dgr_pkg::DIST_MAX;
      if (hit) begin
         r.hit_found = 1'b1;
         r.hit_side = side[0];
         r.hit_row = mx[5:0];
         r.hit_col = my[5:0];
         r.wall_value = wall_map[mx*MAP_N + my];
         r.wall_distance = wall_dist[31:0];
      end
      return r;
   endfunction

   // result checker
   always @(posedge clock) begin
      ray_hit_type got, exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.column_out    = rsp_tdata[11:0];
         got.hit_row       = rsp_tdata[17:12];
         got.hit_col       = rsp_tdata[23:18];
         got.wall_value    = rsp_tdata[31:24];
         got.wall_distance = rsp_tdata[63:32];
         got.hit_found     = rsp_tuser[0];
         got.hit_side      = rsp_tuser[1];
         if (pending_hits.size() == 0) begin
            $error("result with nothing expected: column %0d", got.column_out);
            errors++;
         end else begin
            exp_r = pending_hits.pop_front();
            if (got.hit_found) n_hits++; else n_misses++;
            if (got.column_out != exp_r.column_out) begin
               $error("column_out exp %0d got %0d", exp_r.column_out, got.column_out);
               errors++;
            end
            if (got.hit_found != exp_r.hit_found) begin
               $error("hit_found exp %0d got %0d", exp_r.hit_found, got.hit_found);
               errors++;
            end
            if (got.hit_side != exp_r.hit_side) begin
               $error("hit_side exp %0d got %0d", exp_r.hit_side, got.hit_side);
               errors++;
            end
            if (got.hit_row != exp_r.hit_row) begin
               $error("hit_row exp %0d got %0d", exp_r.hit_row, got.hit_row);
               errors++;
            end
            if (got.hit_col != exp_r.hit_col) begin
               $error("hit_col exp %0d got %0d", exp_r.hit_col, got.hit_col);
               errors++;
            end
            if (got.wall_value != exp_r.wall_value) begin
               $error("wall_value exp %0d got %0d", exp_r.wall_value, got.wall_value);
               errors++;
            end
            if (got.wall_distance != exp_r.wall_distance) begin
               $error("wall_distance exp %0h got %0h", exp_r.wall_distance,
                      got.wall_distance);
               errors++;
            end
         end
      end
   end

   // receiver: random stalls, plus an occasional long hold-off
   always @(posedge clock) begin
      if (hold_req) begin
         hold_req = 0;
         hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // watchdog: cycles without any transaction
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
         $display("watchdog expired, %0d results outstanding", pending_hits.size());
         $display("tb failed");
         $finish;
      end
   end

   task automatic send_item(bit op, logic [5:0] row, logic [5:0] col,
                            logic [7:0] val, logic [11:0] column);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {column, val, col, row};
      do @(posedge clock); while (!req_tready);
      if (op == dgr_pkg::OP_CELL_WRITE) begin
         wall_map[row*MAP_N + col] = val;
         n_writes++;
      end else begin
         pending_hits.push_back(trace_column(column));
         n_casts++;
      end
   endtask

   task automatic cast_col(logic [11:0] column);
      send_item(dgr_pkg::OP_CAST, 6'($urandom), 6'($urandom), 8'($urandom), column);
   endtask

   task automatic put_cell(int row, int col, logic [7:0] val);
      send_item(dgr_pkg::OP_CELL_WRITE, 6'(row), 6'(col), val, 12'($urandom));
   endtask

   // stop offering and let everything outstanding come back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [21:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         dgr_pkg::REG_POS_X:        view_pos_x = val;
         dgr_pkg::REG_POS_Y:        view_pos_y = val;
         dgr_pkg::REG_VIEW_DIR_X:   dir_x = val[17:0];
         dgr_pkg::REG_VIEW_DIR_Y:   dir_y = val[17:0];
         dgr_pkg::REG_CAM_PLANE_X:  plane_x = val[17:0];
         dgr_pkg::REG_CAM_PLANE_Y:  plane_y = val[17:0];
         dgr_pkg::REG_SCREEN_WIDTH: scr_width = val[12:0];
         default: ;
      endcase
      n_csr++;
   endtask

   function automatic logic [21:0] pick_vec18();
      case ($urandom_range(5))
         0: return {4'($urandom), 18'h20000};      // most negative, junk above
         1: return 22'h1FFFF;                      // most positive
         2: return '0;
         default: return 22'($urandom);
      endcase
   endfunction

   task automatic random_view();
      logic [21:0] w;
      drain();
      write_csr(dgr_pkg::REG_POS_X, ($urandom_range(9) == 0) ? 22'h3FFFFF : 22'($urandom));
      write_csr(dgr_pkg::REG_POS_Y, ($urandom_range(9) == 0) ? 22'h0 : 22'($urandom));
      write_csr(dgr_pkg::REG_VIEW_DIR_X, pick_vec18());
      write_csr(dgr_pkg::REG_VIEW_DIR_Y, pick_vec18());
      write_csr(dgr_pkg::REG_CAM_PLANE_X, pick_vec18());
      write_csr(dgr_pkg::REG_CAM_PLANE_Y, pick_vec18());
      case ($urandom_range(4))
         0: w = 22'd4096;
         1: w = 22'd1;
         2: w = 22'($urandom);                     // upper bits ignored by the block
         default: w = 22'($urandom_range(1, 700));
      endcase
      write_csr(dgr_pkg::REG_SCREEN_WIDTH, w);
   endtask

   task automatic test_reset_view();
      // default view over an empty map: every ray walks off the edge
      cast_col(12'd0);
      cast_col(12'd320);
      cast_col(12'd639);
      // short wall just in front of the viewer's x
      for (int c = 28; c <= 36; c++) put_cell(31, c, 8'hFF);
      put_cell(63, 63, 8'h01);
      put_cell(64 - 1, 0, 8'h80);
      cast_col(12'd0);
      cast_col(12'd320);
      cast_col(12'd639);
      cast_col(12'd640);                           // column past the screen edge
      cast_col(12'd4095);
      drain();
   endtask

   task automatic test_axis_rays();
      // plane zero: both components of the ray fixed, one of them zero
      write_csr(dgr_pkg::REG_CAM_PLANE_X, 22'd0);
      write_csr(dgr_pkg::REG_CAM_PLANE_Y, 22'd0);
      write_csr(dgr_pkg::REG_VIEW_DIR_X, 22'd0);
      write_csr(dgr_pkg::REG_VIEW_DIR_Y, 22'h10000);
      cast_col(12'd5);
      drain();
      write_csr(dgr_pkg::REG_SCREEN_WIDTH, 22'd0); // width zero behaves as one
      cast_col(12'd0);
      cast_col(12'd1);
      drain();
      write_csr(dgr_pkg::REG_VIEW_DIR_Y, 22'd0);   // null ray
      cast_col(12'd7);
      put_cell(31, 32, 8'h00);                     // clear a wall again
      drain();
   endtask

   task automatic random_items(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 45)
            put_cell($urandom_range(63), $urandom_range(63),
                     ($urandom_range(4) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
         else if ($urandom_range(9) == 0)
            cast_col(12'($urandom));
         else
            cast_col(12'($urandom_range(0, (scr_width == 0) ? 0 : scr_width - 1)));
      end
   endtask

   task automatic test_random(int idle_pct, int stall_pct);
      req_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int p = 0; p < 3; p++) begin
         random_view();
         random_items(90);
      end
      drain();
   endtask

   task automatic test_backpressure();
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_req = 1;
      for (int i = 0; i < 8; i++) cast_col(12'($urandom_range(0, 63)));
      drain();
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      view_pos_x = dgr_pkg::POS_X_RST;
      view_pos_y = dgr_pkg::POS_Y_RST;
      dir_x = dgr_pkg::VIEW_DIR_X_RST;
      dir_y = dgr_pkg::VIEW_DIR_Y_RST;
      plane_x = dgr_pkg::CAM_PLANE_X_RST;
      plane_y = dgr_pkg::CAM_PLANE_Y_RST;
      scr_width = dgr_pkg::SCREEN_WIDTH_RST;
      foreach (wall_map[i]) wall_map[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_view();
      test_axis_rays();
      test_random(35, 66);
      test_random(66, 35);
      test_backpressure();
      test_random(0, 0);

      drain();
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("covered %0d map writes, %0d casts (%0d hits, %0d misses), %0d CSR writes",
               n_writes, n_casts, n_hits, n_misses, n_csr);
      if (errors == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/dgr_pkg.sv
sv/dgr_div.sv
sv/dgr_map.sv
sv/dda_grid_raycaster_unit.sv
tb/sv/tb.sv
